// ===== rtl/core/kdll_pkg.sv =====
package kdll_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    localparam int CMD_W      = 3;
    localparam int KEY_PORT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 7;

    localparam int GROUP_SIZE = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== rtl/core/kdll_free_finder.sv =====
module kdll_free_finder
    import kdll_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic                aclk,
    input  logic [CAPACITY-1:0] used,
    output logic [IDX_W-1:0]    free_slot
);

    localparam int NG    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_N = NG * GROUP_SIZE;
    localparam int POS_W = $clog2(GROUP_SIZE);
    localparam int PW    = $clog2(PAD_N);

    logic [PAD_N-1:0] padded;
    logic             grp_any [NG];
    logic [POS_W-1:0] grp_pos [NG];
    logic             grp_any_reg [NG];
    logic [POS_W-1:0] grp_pos_reg [NG];
    logic [PW-1:0]    sel;

    // Each group of eight slots is searched on its own and registered; the
    // lowest group with a free slot is picked in the following cycle.
    always_comb begin
        padded = '1;
        padded[CAPACITY-1:0] = used;
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = 1'b0;
            grp_pos[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
                if (!padded[g*GROUP_SIZE + b]) begin
                    grp_any[g] = 1'b1;
                    grp_pos[g] = POS_W'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            grp_any_reg[g] <= grp_any[g];
            grp_pos_reg[g] <= grp_pos[g];
        end
    end

    always_comb begin
        sel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                sel = PW'(g * GROUP_SIZE) + PW'(grp_pos_reg[g]);
            end
        end
    end

    assign free_slot = sel[IDX_W-1:0];

endmodule

// ===== rtl/core/keyed_deque_linked_list.sv =====
// Insert passes through S_INSERT, and delete-first and delete-last through S_UNLINK, before S_RESP
// loads the result into the output register; errors and unused commands go straight to S_RESP.
// Delete by key walks the list in S_SCAN at one entry per cycle, then S_UNLINK when found, then S_RESP.
// A dump gives one result per entry, at one per cycle while the output register is free.
// The output register lets the next item be accepted while a result still waits.
// Reset is synchronous and active low; it empties the list, and memory contents are not cleared.
module keyed_deque_linked_list
    import kdll_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_command,
    input  logic signed [KEY_PORT_W-1:0] s_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [KEY_PORT_W-1:0] m_value,
    output logic                       m_value_valid,
    output logic [TOTAL_W-1:0]         m_entry_total,
    output logic                       m_last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int XW    = (KEY_WIDTH > KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_UNLINK,
        S_DUMP,
        S_RESP
    } state_t;

    state_t state_reg;

    logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
    logic [IDX_W-1:0]     next_mem [CAPACITY];
    logic [IDX_W-1:0]     prev_mem [CAPACITY];

    logic [KEY_WIDTH-1:0] key_q;
    logic [IDX_W-1:0]     next_q;
    logic [IDX_W-1:0]     prev_q;

    logic [CAPACITY-1:0]  used_reg;
    logic [IDX_W-1:0]     front_reg;
    logic [IDX_W-1:0]     back_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     cur_reg;
    logic [CNT_W-1:0]     step_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [KEY_PORT_W-1:0] m_value_reg;
    logic                 m_value_valid_reg;
    logic [TOTAL_W-1:0]   m_entry_total_reg;
    logic                 m_last_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 key_we;
    logic                 next_we;
    logic [IDX_W-1:0]     next_waddr;
    logic [IDX_W-1:0]     next_wdata;
    logic                 prev_we;
    logic [IDX_W-1:0]     prev_waddr;
    logic [IDX_W-1:0]     prev_wdata;

    logic [IDX_W-1:0]     free_slot;
    logic signed [XW-1:0] in_key_ext;
    logic signed [XW-1:0] out_key_ext;
    logic [KEY_WIDTH-1:0] key_in;
    logic                 out_free;
    logic                 out_load;
    logic                 walk_last;
    logic                 key_match;
    logic                 list_empty;

    kdll_free_finder #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_free_finder (
        .aclk      (aclk),
        .used      (used_reg),
        .free_slot (free_slot)
    );

    assign in_key_ext  = XW'(s_key);
    assign key_in      = in_key_ext[KEY_WIDTH-1:0];
    assign out_key_ext = XW'($signed(key_q));
    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = out_free && (state_reg == S_DUMP || state_reg == S_RESP);
    assign walk_last   = (step_reg + CNT_W'(1)) == count_reg;
    assign key_match   = key_q == key_reg;
    assign list_empty  = count_reg == '0;

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_value       = m_value_reg;
    assign m_value_valid = m_value_valid_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_last        = m_last_reg;

    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        key_we     = 1'b0;
        next_we    = 1'b0;
        next_waddr = free_slot;
        next_wdata = front_reg;
        prev_we    = 1'b0;
        prev_waddr = front_reg;
        prev_wdata = free_slot;
        case (state_reg)
            S_IDLE: begin
                rd_en   = s_valid;
                rd_addr = (s_command == CMD_DEL_LAST) ? back_reg : front_reg;
            end
            S_INSERT: begin
                key_we     = 1'b1;
                next_we    = 1'b1;
                next_wdata = list_empty ? free_slot : front_reg;
                prev_we    = !list_empty;
            end
            S_SCAN: begin
                if (!key_match && !walk_last) begin
                    rd_en   = 1'b1;
                    rd_addr = next_q;
                end
            end
            S_UNLINK: begin
                if (count_reg != CNT_W'(1) && cur_reg != front_reg && cur_reg != back_reg) begin
                    next_we    = 1'b1;
                    next_waddr = prev_q;
                    next_wdata = next_q;
                    prev_we    = 1'b1;
                    prev_waddr = next_q;
                    prev_wdata = prev_q;
                end
            end
            S_DUMP: begin
                if (out_free && !walk_last) begin
                    rd_en   = 1'b1;
                    rd_addr = next_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[free_slot] <= key_reg;
        end
        if (rd_en) begin
            key_q <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (rd_en) begin
            next_q <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (rd_en) begin
            prev_q <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        key_reg    <= key_in;
                        cur_reg    <= (s_command == CMD_DEL_LAST) ? back_reg : front_reg;
                        step_reg   <= '0;
                        status_reg <= ST_OK;
                        case (s_command)
                            CMD_INSERT: begin
                                if (count_reg == CNT_W'(CAPACITY)) begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_RESP;
                                end else begin
                                    state_reg <= S_INSERT;
                                end
                            end
                            CMD_DEL_KEY: begin
                                if (list_empty) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            CMD_DEL_FIRST, CMD_DEL_LAST: begin
                                if (list_empty) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                end else begin
                                    state_reg <= S_UNLINK;
                                end
                            end
                            CMD_DUMP: begin
                                if (list_empty) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_RESP;
                                end else begin
                                    state_reg <= S_DUMP;
                                end
                            end
                            default: begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    used_reg[free_slot] <= 1'b1;
                    front_reg           <= free_slot;
                    if (list_empty) begin
                        back_reg <= free_slot;
                    end
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_RESP;
                end
                S_SCAN: begin
                    if (key_match) begin
                        state_reg <= S_UNLINK;
                    end else if (walk_last) begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_RESP;
                    end else begin
                        cur_reg  <= next_q;
                        step_reg <= step_reg + CNT_W'(1);
                    end
                end
                S_UNLINK: begin
                    if (count_reg == CNT_W'(1)) begin
                        front_reg <= '0;
                        back_reg  <= '0;
                    end else if (cur_reg == front_reg) begin
                        front_reg <= next_q;
                    end else if (cur_reg == back_reg) begin
                        back_reg <= prev_q;
                    end
                    used_reg[cur_reg] <= 1'b0;
                    count_reg         <= count_reg - CNT_W'(1);
                    state_reg         <= S_RESP;
                end
                S_DUMP: begin
                    if (out_free) begin
                        m_status_reg      <= ST_OK;
                        m_value_reg       <= out_key_ext[KEY_PORT_W-1:0];
                        m_value_valid_reg <= 1'b1;
                        m_entry_total_reg <= TOTAL_W'(count_reg);
                        m_last_reg        <= walk_last;
                        if (walk_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            cur_reg  <= next_q;
                            step_reg <= step_reg + CNT_W'(1);
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_status_reg      <= status_reg;
                        m_value_reg       <= '0;
                        m_value_valid_reg <= 1'b0;
                        m_entry_total_reg <= TOTAL_W'(count_reg);
                        m_last_reg        <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
